>>> src/rounded_square_path_setpoint_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rounded square path setpoint block
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_SQUARE_PATH_SETPOINT_DEFINES_SVH
`define ROUNDED_SQUARE_PATH_SETPOINT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RSPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rsps_pkg.sv
// ----------------------------------------------------------------------------
// rsps_pkg
// Types, codes and constants shared by the rounded square path setpoint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsps_pkg;

	localparam int ANGLE_BITS = 17;
	localparam logic [16:0] ANGLE_LIMIT = 17'd102891;
	localparam logic [16:0] ANGLE_LIMIT_P1 = 17'd102892;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [21:0] POS_MAX = 22'd4194303;

	// Configuration register indexes
	localparam logic [1:0] REG_CRUISE = 2'd0;
	localparam logic [1:0] REG_TURN = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_SIDE = 2'd3;

	// Path segments
	localparam logic [2:0] SEG_RUN_X = 3'd0;
	localparam logic [2:0] SEG_ARC_1 = 3'd1;
	localparam logic [2:0] SEG_RUN_UP = 3'd2;
	localparam logic [2:0] SEG_ARC_2 = 3'd3;
	localparam logic [2:0] SEG_RUN_BACK = 3'd4;
	localparam logic [2:0] SEG_ARC_3 = 3'd5;
	localparam logic [2:0] SEG_RUN_DOWN = 3'd6;
	localparam logic [2:0] SEG_DONE = 3'd7;

	typedef struct packed {
		logic        busy;
		logic [19:0] vc;
		logic [19:0] vt;
		logic [21:0] radius;
		logic [21:0] side;
		logic [21:0] rdiv;
		logic [38:0] lim;
		logic [6:0][41:0] ts;
	} timing_t;

	typedef struct packed {
		logic [2:0]  seg;
		logic [35:0] mv;
		logic        sat;
	} carry_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] a;
		case (i)
			0: a = 30'd843314857;
			1: a = 30'd497837829;
			2: a = 30'd263043837;
			3: a = 30'd133525159;
			4: a = 30'd67021687;
			5: a = 30'd33543516;
			6: a = 30'd16775851;
			7: a = 30'd8388437;
			8: a = 30'd4194283;
			9: a = 30'd2097149;
			10: a = 30'd1048576;
			11: a = 30'd524288;
			12: a = 30'd262144;
			13: a = 30'd131072;
			14: a = 30'd65536;
			15: a = 30'd32768;
			16: a = 30'd16384;
			17: a = 30'd8192;
			18: a = 30'd4096;
			19: a = 30'd2048;
			20: a = 30'd1024;
			21: a = 30'd512;
			22: a = 30'd256;
			23: a = 30'd128;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

>>> src/rounded_square_path_setpoint.sv
// ----------------------------------------------------------------------------
// rounded_square_path_setpoint
// Reference position on a closed square path with rounded corners, one
// elapsed-time sample in and one setpoint out.
// ----------------------------------------------------------------------------
//  channel    direction  handshake                 payload
//  sample     in         sample_valid/stall        elapsed_time
//  setpoint   out        setpoint_valid/stall      position_x, position_y, segment
//  cfg        in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One sample is taken every cycle while sample_stall is low; the pipeline
// holds the seventeen angle division cells and the CORDIC cell row.
// After reset and after every configuration write the boundary times are
// recomputed by a bit-serial divider, with sample_stall high.
// A two-entry output stage (output register and skid) holds results while
// setpoint_stall is high; sample_stall also rises once the skid is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rounded_square_path_setpoint #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [31:0] elapsed_time,
	output logic        setpoint_valid,
	input  logic        setpoint_stall,
	output logic [21:0] position_x,
	output logic [21:0] position_y,
	output logic [2:0]  segment,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data
);
	import rsps_pkg::*;

	timing_t tim;

	rsps_timing u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tim       (tim)
	);

	logic en, accept;
	logic skid_v_q, out_v_q;

	assign en = !skid_v_q;
	assign sample_stall = tim.busy || skid_v_q;
	assign accept = sample_valid && !sample_stall;

	// Segment search and time into the segment.
	logic [2:0]  seg_c;
	logic [41:0] start_c, t_e;

	assign t_e = {10'd0, elapsed_time};

	always_comb begin
		seg_c = SEG_DONE;
		for (int k = 6; k >= 0; k--) begin
			if (t_e < tim.ts[k]) begin
				seg_c = 3'(k);
			end
		end
	end

	always_comb begin
		case (seg_c)
			SEG_ARC_1: start_c = tim.ts[0];
			SEG_RUN_UP: start_c = tim.ts[1];
			SEG_ARC_2: start_c = tim.ts[2];
			SEG_RUN_BACK: start_c = tim.ts[3];
			SEG_ARC_3: start_c = tim.ts[4];
			SEG_RUN_DOWN: start_c = tim.ts[5];
			default: start_c = 42'd0;
		endcase
	end

	logic        v_s1, v_s2, v_s3;
	logic [2:0]  seg_s1, seg_s2, seg_s3;
	logic [31:0] dlt_s1;
	logic [35:0] mv_s2, mv_s3;
	logic [51:0] prod_s2;
	logic        sat_s3;
	logic [38:0] rem_s3;
	logic [51:0] mvp, angp;

	assign mvp = 52'(tim.vc) * 52'(dlt_s1);
	assign angp = 52'(dlt_s1) * 52'(tim.vt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg_c;
			dlt_s1 <= 32'(t_e - start_c);
			seg_s2 <= seg_s1;
			mv_s2 <= mvp[51:16];
			prod_s2 <= angp;
			seg_s3 <= seg_s2;
			mv_s3 <= mv_s2;
			// Beyond the limit the angle saturates, so the division gets a zero remainder.
			sat_s3 <= prod_s2 >= {13'd0, tim.lim};
			rem_s3 <= (prod_s2 >= {13'd0, tim.lim}) ? 39'd0 : prod_s2[38:0];
		end
	end

	// Angle division cells.
	logic [ANGLE_BITS:0]        dv;
	logic [ANGLE_BITS:0][38:0]  drem;
	logic [ANGLE_BITS:0][16:0]  dquo;
	carry_t [ANGLE_BITS:0]      dcar;

	assign dv[0] = v_s3;
	assign drem[0] = rem_s3;
	assign dquo[0] = 17'd0;
	assign dcar[0] = '{seg: seg_s3, mv: mv_s3, sat: sat_s3};

	for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_div
		rsps_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor ({tim.rdiv, 16'd0}),
			.valid_i (dv[i]),
			.rem_i   (drem[i]),
			.quo_i   (dquo[i]),
			.car_i   (dcar[i]),
			.valid_q (dv[i+1]),
			.rem_q   (drem[i+1]),
			.quo_q   (dquo[i+1]),
			.car_q   (dcar[i+1])
		);
	end

	// CORDIC cells.
	logic [16:0] ang;
	logic [CORDIC_STEPS:0]               cv;
	logic signed [CORDIC_STEPS:0][32:0]  cx, cy, cz;
	carry_t [CORDIC_STEPS:0]             ccar;

	assign ang = dcar[ANGLE_BITS].sat ? ANGLE_LIMIT : dquo[ANGLE_BITS];
	assign cv[0] = dv[ANGLE_BITS];
	assign cx[0] = CORDIC_GAIN;
	assign cy[0] = 33'sd0;
	assign cz[0] = $signed({2'd0, ang, 14'd0});
	assign ccar[0] = dcar[ANGLE_BITS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		rsps_cordic_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (cv[i]),
			.x_i     (cx[i]),
			.y_i     (cy[i]),
			.z_i     (cz[i]),
			.car_i   (ccar[i]),
			.valid_q (cv[i+1]),
			.x_q     (cx[i+1]),
			.y_q     (cy[i+1]),
			.z_q     (cz[i+1]),
			.car_q   (ccar[i+1])
		);
	end

	// Radius scaling of sine and cosine. An element of a packed array is
	// unsigned, so the sign is restored before the multiply.
	logic signed [55:0] psn, pcs;
	logic               v_s4;
	logic [2:0]         seg_s4;
	logic [35:0]        mv_s4;
	logic signed [25:0] sr_s4, cr_s4;

	assign psn = $signed({1'b0, tim.radius}) * $signed(cy[CORDIC_STEPS]);
	assign pcs = $signed({1'b0, tim.radius}) * $signed(cx[CORDIC_STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s4 <= ccar[CORDIC_STEPS].seg;
			mv_s4 <= ccar[CORDIC_STEPS].mv;
			sr_s4 <= psn[55:30];
			cr_s4 <= pcs[55:30];
		end
	end

	// Position assembly and saturation.
	logic signed [39:0] lw, rw, mw, sw, cw, lr, xw, yw;
	logic [21:0]        x_sat, y_sat;

	assign lw = $signed({18'd0, tim.side});
	assign rw = $signed({18'd0, tim.radius});
	assign mw = $signed({4'd0, mv_s4});
	assign sw = 40'(sr_s4);
	assign cw = 40'(cr_s4);
	assign lr = lw - rw;

	always_comb begin
		case (seg_s4)
			SEG_RUN_X: begin
				xw = mw;
				yw = 40'sd0;
			end
			SEG_ARC_1: begin
				xw = lr + sw;
				yw = rw - cw;
			end
			SEG_RUN_UP: begin
				xw = lw;
				yw = rw + mw;
			end
			SEG_ARC_2: begin
				xw = lr + cw;
				yw = lr + sw;
			end
			SEG_RUN_BACK: begin
				xw = lr - mw;
				yw = lw;
			end
			SEG_ARC_3: begin
				xw = rw - sw;
				yw = lr + cw;
			end
			SEG_RUN_DOWN: begin
				xw = 40'sd0;
				yw = lr - mw;
			end
			default: begin
				xw = 40'sd0;
				yw = 40'sd0;
			end
		endcase
	end

	assign x_sat = xw[39] ? 22'd0 : ((xw > $signed({18'd0, POS_MAX})) ? POS_MAX : xw[21:0]);
	assign y_sat = yw[39] ? 22'd0 : ((yw > $signed({18'd0, POS_MAX})) ? POS_MAX : yw[21:0]);

	// Output register with a skid entry behind it.
	logic        out_load;
	logic [21:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic [2:0]  out_seg_q, skid_seg_q;

	assign out_load = !out_v_q || !setpoint_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_load) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s4;
			end
		end else if (v_s4 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_v_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_seg_q <= skid_seg_q;
			end else begin
				out_x_q <= x_sat;
				out_y_q <= y_sat;
				out_seg_q <= seg_s4;
			end
		end else if (en) begin
			skid_x_q <= x_sat;
			skid_y_q <= y_sat;
			skid_seg_q <= seg_s4;
		end
	end

	assign setpoint_valid = out_v_q;
	assign position_x = out_x_q;
	assign position_y = out_y_q;
	assign segment = out_seg_q;

endmodule

>>> src/rsps_timing.sv
// ----------------------------------------------------------------------------
// rsps_timing
// Configuration registers and the segment boundary times derived from them,
// worked out by a shared bit-serial divider after reset and after each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsps_timing (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [21:0]       cfg_data,
	output rsps_pkg::timing_t tim
);
	import rsps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_SUM = 3'd3;

	localparam logic [1:0] JOB_D1 = 2'd0;
	localparam logic [1:0] JOB_D2 = 2'd1;
	localparam logic [1:0] JOB_DT = 2'd2;

	logic [19:0] cruise_q, turn_q;
	logic [21:0] radius_q, side_q;
	logic [2:0]  state_q;
	logic [1:0]  job_q;
	logic [5:0]  cnt_q;
	logic [2:0]  k_q;
	logic [45:0] num_q;
	logic [26:0] den_q, rem_q;
	logic [41:0] d1_q, d2_q, dt_q, acc_q;
	logic [6:0][41:0] ts_q;
	logic [38:0] lim_q;

	logic [19:0] vc, vt;
	logic [21:0] rdiv;
	logic [22:0] side_e, r2;
	logic [29:0] rt;
	logic [45:0] num_sel;
	logic [26:0] den_sel;
	logic [27:0] rem_sh;
	logic        ge;
	logic [45:0] quo;
	logic [41:0] dur, acc_n;

	assign vc = (cruise_q == 20'd0) ? 20'd1 : cruise_q;
	assign vt = (turn_q == 20'd0) ? 20'd1 : turn_q;
	assign rdiv = (radius_q == 22'd0) ? 22'd1 : radius_q;
	assign side_e = {1'b0, side_q};
	assign r2 = {radius_q, 1'b0};
	assign rt = 30'(radius_q) * 30'd157;

	always_comb begin
		case (job_q)
			JOB_D1: begin
				num_sel = (side_q > radius_q) ? {8'd0, side_q - radius_q, 16'd0} : 46'd0;
				den_sel = 27'(vc);
			end
			JOB_D2: begin
				num_sel = (side_e > r2) ? {7'd0, side_e - r2, 16'd0} : 46'd0;
				den_sel = 27'(vc);
			end
			default: begin
				num_sel = {rt, 16'd0};
				den_sel = 27'(vt) * 27'd100;
			end
		endcase
	end

	assign rem_sh = {rem_q, num_q[45]};
	assign ge = rem_sh >= {1'b0, den_q};
	assign quo = {num_q[44:0], ge};

	always_comb begin
		case (k_q)
			3'd0, 3'd6: dur = d1_q;
			3'd2, 3'd4: dur = d2_q;
			default: dur = dt_q;
		endcase
	end
	assign acc_n = acc_q + dur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_q <= 20'd32768;
			turn_q <= 20'd19661;
			radius_q <= 22'd131072;
			side_q <= 22'd655360;
			state_q <= ST_LOAD;
			job_q <= JOB_D1;
			cnt_q <= 6'd0;
			k_q <= 3'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_CRUISE: cruise_q <= cfg_data[19:0];
							REG_TURN: turn_q <= cfg_data[19:0];
							REG_RADIUS: radius_q <= cfg_data;
							REG_SIDE: side_q <= cfg_data;
							default: ;
						endcase
						state_q <= ST_LOAD;
						job_q <= JOB_D1;
					end
				end
				ST_LOAD: begin
					cnt_q <= 6'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd45) begin
						if (job_q == JOB_DT) begin
							state_q <= ST_SUM;
							k_q <= 3'd0;
						end else begin
							job_q <= job_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_SUM: begin
					if (k_q == 3'd6) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath registers of the divider and the boundary accumulator.
	always_ff @(posedge clk) begin
		lim_q <= 39'(rdiv) * 39'(ANGLE_LIMIT_P1);
		case (state_q)
			ST_LOAD: begin
				num_q <= num_sel;
				den_q <= den_sel;
				rem_q <= 27'd0;
				acc_q <= 42'd0;
			end
			ST_DIV: begin
				num_q <= quo;
				rem_q <= ge ? 27'(rem_sh - {1'b0, den_q}) : rem_sh[26:0];
				if (cnt_q == 6'd45) begin
					case (job_q)
						JOB_D1: d1_q <= quo[41:0];
						JOB_D2: d2_q <= quo[41:0];
						default: dt_q <= quo[41:0];
					endcase
				end
			end
			ST_SUM: begin
				acc_q <= acc_n;
				ts_q[k_q] <= acc_n;
			end
			default: ;
		endcase
	end

	assign cfg_ready = (state_q == ST_IDLE);

	always_comb begin
		tim.busy = (state_q != ST_IDLE);
		tim.vc = vc;
		tim.vt = vt;
		tim.radius = radius_q;
		tim.side = side_q;
		tim.rdiv = rdiv;
		tim.lim = lim_q;
		tim.ts = ts_q;
	end

endmodule

>>> src/rsps_div_cell.sv
// ----------------------------------------------------------------------------
// rsps_div_cell
// One restoring division step of the arc angle: yields one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsps_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [37:0]      divisor,
	input  logic             valid_i,
	input  logic [38:0]      rem_i,
	input  logic [16:0]      quo_i,
	input  rsps_pkg::carry_t car_i,
	output logic             valid_q,
	output logic [38:0]      rem_q,
	output logic [16:0]      quo_q,
	output rsps_pkg::carry_t car_q
);
	import rsps_pkg::*;

	logic        ge;
	logic [38:0] rem_n;

	assign ge = rem_i >= {1'b0, divisor};
	assign rem_n = ge ? rem_i - {1'b0, divisor} : rem_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= {rem_n[37:0], 1'b0};
			quo_q <= {quo_i[15:0], ge};
			car_q <= car_i;
		end
	end

endmodule

>>> src/rsps_cordic_cell.sv
// ----------------------------------------------------------------------------
// rsps_cordic_cell
// One rotation-mode CORDIC micro-rotation by the arctangent of 2^-IDX.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsps_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  logic signed [32:0]  x_i,
	input  logic signed [32:0]  y_i,
	input  logic signed [32:0]  z_i,
	input  rsps_pkg::carry_t    car_i,
	output logic                valid_q,
	output logic signed [32:0]  x_q,
	output logic signed [32:0]  y_q,
	output logic signed [32:0]  z_q,
	output rsps_pkg::carry_t    car_q
);
	import rsps_pkg::*;

	localparam logic signed [32:0] ATAN = $signed({3'd0, atan_q30(IDX)});

	logic signed [32:0] dx, dy;

	// Arithmetic shifts round towards minus infinity, as required.
	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[32]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - ATAN;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + ATAN;
			end
			car_q <= car_i;
		end
	end

endmodule

>>> src/rsps_checker.sv
// ----------------------------------------------------------------------------
// rsps_checker
// Port-level assertions for the rounded square path setpoint, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rounded_square_path_setpoint_defines.svh"

module rsps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_stall,
	input logic        setpoint_valid,
	input logic        setpoint_stall,
	input logic [21:0] position_x,
	input logic [21:0] position_y,
	input logic [2:0]  segment,
	input logic        cfg_ready
);
	import rsps_pkg::*;

	// No sample transfer while the boundary times are being recomputed.
	`RSPS_ASSERT_IMP(a_busy_stalls, !cfg_ready, sample_stall, "sample taken while busy")

	// A finished path always holds at the origin.
	`RSPS_ASSERT_IMP(a_done_origin, setpoint_valid && segment == SEG_DONE,
		position_x == 22'd0 && position_y == 22'd0, "finished path not at origin")

	// The first straight run stays on the x axis.
	`RSPS_ASSERT_IMP(a_first_run_y, setpoint_valid && segment == SEG_RUN_X,
		position_y == 22'd0, "first run left the x axis")

	// A stalled setpoint stays put.
	`RSPS_ASSERT_NEXT(a_out_hold, setpoint_valid && setpoint_stall,
		setpoint_valid && $stable(position_x) && $stable(position_y) && $stable(segment),
		"stalled setpoint changed")

endmodule

bind rounded_square_path_setpoint rsps_checker u_rsps_checker (.*);

>>> tb/sv/path_setpoint_checker.sv
// ----------------------------------------------------------------------------
// Path setpoint checker
// Watches the sample, setpoint and configuration channels, predicts each
// setpoint from the accepted sample and the live register copy, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module path_setpoint_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  logic [31:0] elapsed_time,
	input  logic        setpoint_valid,
	input  logic        setpoint_stall,
	input  logic [21:0] position_x,
	input  logic [21:0] position_y,
	input  logic [2:0]  segment,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data,
	output int          fail_count,
	output int          pending_count
);
	import rsps_pkg::*;

	typedef struct packed {
		logic [21:0] x;
		logic [21:0] y;
		logic [2:0]  seg;
	} setpoint_t;

	setpoint_t expected_setpoints[$];
	logic [19:0] cruise_reg, turn_reg;
	logic [21:0] radius_reg, side_reg;

	localparam logic [29:0] ATAN_TABLE [24] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128};

	function automatic longint sat_pos(input longint v);
		if (v < 0)
			return 0;
		if (v > 64'sd4194303)
			return 64'sd4194303;
		return v;
	endfunction

	// Arithmetic right shift floors, which is what the arc scaling needs.
	function automatic void arc_sin_cos(input longint angle, output longint sn,
			output longint cs);
		longint x, y, z, dx, dy;
		int n;
		x = 652032874;
		y = 0;
		z = angle * 16384;
		n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
			end
		end
		sn = y;
		cs = x;
	endfunction

	function automatic setpoint_t predict_setpoint(input logic [31:0] t_in);
		longint unsigned t, vc, vt, ru, lu, rdiv, d1, d2, dt, start, dlt, ang;
		longint unsigned bound [7];
		longint r, side, sn, cs, x, y, mv, rs, rc;
		int seg;
		setpoint_t res;
		t = t_in;
		vc = cruise_reg ? cruise_reg : 1;
		vt = turn_reg ? turn_reg : 1;
		ru = radius_reg;
		lu = side_reg;
		rdiv = ru ? ru : 1;
		d1 = lu > ru ? ((lu - ru) << 16) / vc : 0;
		d2 = lu > 2 * ru ? ((lu - 2 * ru) << 16) / vc : 0;
		dt = ((ru * 157) << 16) / (100 * vt);
		bound[0] = d1;
		bound[1] = bound[0] + dt;
		bound[2] = bound[1] + d2;
		bound[3] = bound[2] + dt;
		bound[4] = bound[3] + d2;
		bound[5] = bound[4] + dt;
		bound[6] = bound[5] + d1;
		seg = 7;
		for (int k = 6; k >= 0; k--)
			if (t < bound[k])
				seg = k;
		start = (seg > 0 && seg < 7) ? bound[seg - 1] : 0;
		dlt = t - start;
		mv = longint'((vc * dlt) >> 16);
		r = ru;
		side = lu;
		sn = 0;
		cs = 0;
		if (seg == 1 || seg == 3 || seg == 5) begin
			ang = (dlt * vt) / rdiv;
			if (ang > 102891)
				ang = 102891;
			arc_sin_cos(longint'(ang), sn, cs);
		end
		rs = (r * sn) >>> 30;
		rc = (r * cs) >>> 30;
		case (seg)
			0: begin x = mv; y = 0; end
			1: begin x = side - r + rs; y = r - rc; end
			2: begin x = side; y = r + mv; end
			3: begin x = side - r + rc; y = side - r + rs; end
			4: begin x = side - r - mv; y = side; end
			5: begin x = r - rs; y = side - r + rc; end
			6: begin x = 0; y = side - r - mv; end
			default: begin x = 0; y = 0; end
		endcase
		res.x = 22'(sat_pos(x));
		res.y = 22'(sat_pos(y));
		res.seg = 3'(seg);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		setpoint_t want;
		int errs;
		if (!arst_n) begin
			cruise_reg <= 20'd32768;
			turn_reg <= 20'd19661;
			radius_reg <= 22'd131072;
			side_reg <= 22'd655360;
			fail_count <= 0;
			pending_count <= 0;
			expected_setpoints.delete();
		end else begin
			errs = 0;
			if (sample_valid && !sample_stall)
				expected_setpoints = {expected_setpoints, predict_setpoint(elapsed_time)};
			if (setpoint_valid && !setpoint_stall) begin
				if (expected_setpoints.size() == 0) begin
					$error("unexpected setpoint x=%0d y=%0d seg=%0d",
						position_x, position_y, segment);
					errs = errs + 1;
				end else begin
					want = expected_setpoints.pop_front();
					if (position_x !== want.x) begin
						$error("position_x expected %0d actual %0d", want.x, position_x);
						errs = errs + 1;
					end
					if (position_y !== want.y) begin
						$error("position_y expected %0d actual %0d", want.y, position_y);
						errs = errs + 1;
					end
					if (segment !== want.seg) begin
						$error("segment expected %0d actual %0d", want.seg, segment);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= expected_setpoints.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CRUISE: cruise_reg <= cfg_data[19:0];
					REG_TURN: turn_reg <= cfg_data[19:0];
					REG_RADIUS: radius_reg <= cfg_data;
					REG_SIDE: side_reg <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Rounded square path setpoint testbench
// Drives directed and random elapsed-time samples across several register
// settings with random gaps on both sides; the checker does the comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rsps_pkg::*;

	localparam int LATENCY = 22 + 16;
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic [31:0] elapsed_time = '0;
	logic        setpoint_valid;
	logic        setpoint_stall = 1'b0;
	logic [21:0] position_x, position_y;
	logic [2:0]  segment;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_CRUISE;
	logic [21:0] cfg_data = '0;
	int          fail_count, pending_count;
	int          idle_cycles = 0;
	bit          stall_enable = 1'b1;

	always #5 clk = ~clk;

	rounded_square_path_setpoint DUT (.*);

	path_setpoint_checker checker_inst (.*);

	// Receiver stall: random hold-off periods on setpoint_stall while stall_enable is set.
	initial begin
		int wait_n;
		forever begin
			@(posedge clk);
			if (stall_enable && $urandom_range(0, 3) != 0) begin
				wait_n = $urandom_range(0, 12);
				setpoint_stall <= (wait_n != 0);
				repeat (wait_n) @(posedge clk);
				setpoint_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (setpoint_valid && !setpoint_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_register(input logic [1:0] idx, input logic [21:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [31:0] t, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elapsed_time <= t;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_setting(input logic [19:0] vc, input logic [19:0] vt,
			input logic [21:0] r, input logic [21:0] side);
		write_register(REG_CRUISE, {2'b0, vc});
		write_register(REG_TURN, {2'b0, vt});
		write_register(REG_RADIUS, r);
		write_register(REG_SIDE, side);
	endtask

	// Full path duration under the current setting, used to aim random samples.
	function automatic longint unsigned path_span(input longint unsigned vc,
			input longint unsigned vt, input longint unsigned r,
			input longint unsigned side);
		longint unsigned d1, d2, dt;
		if (vc == 0) vc = 1;
		if (vt == 0) vt = 1;
		d1 = side > r ? ((side - r) << 16) / vc : 0;
		d2 = side > 2 * r ? ((side - 2 * r) << 16) / vc : 0;
		dt = ((r * 157) << 16) / (100 * vt);
		return 2 * d1 + 2 * d2 + 3 * dt;
	endfunction

	task automatic random_phase(input int count, input longint unsigned span);
		logic [31:0] t;
		longint unsigned top;
		top = (span + span / 8 + 1 > 64'hFFFFFFFF) ? 64'hFFFFFFFF : span + span / 8 + 1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				t = $urandom();
			else
				t = 32'(({$urandom(), $urandom()} % top));
			send_sample(t, (i % 100) >= 20);
		end
	endtask

	initial begin
		logic [19:0] vc, vt;
		logic [21:0] r, side;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset setting: the path start, finished-path times and the extremes.
		send_sample(32'd0, 1'b0);
		send_sample(32'hFFFFFFFF, 1'b0);
		send_sample(32'hAAAAAAAA, 1'b0);
		send_sample(32'h55555555, 1'b0);
		for (int k = 0; k < 16; k++)
			send_sample(32'(k) * 32'd6000000, 1'b0);
		drain_results();

		// Zero speeds act as one; zero radius removes the arcs.
		load_setting(20'd0, 20'd0, 22'd0, 22'd655360);
		send_sample(32'd0, 1'b0);
		send_sample(32'hFFFFFFFF, 1'b0);
		send_sample(32'd65536, 1'b0);
		drain_results();

		// Side shorter than the corners, and extreme register values.
		load_setting(20'hFFFFF, 20'hFFFFF, 22'h3FFFFF, 22'd1);
		send_sample(32'd0, 1'b0);
		send_sample(32'd200, 1'b0);
		send_sample(32'd400, 1'b0);
		drain_results();

		random_phase(150, path_span(32768, 19661, 131072, 655360));
		drain_results();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin vc = 20'hFFFFF; vt = 20'hFFFFF; r = 22'd1; side = 22'h3FFFFF; end
				1: begin vc = 20'd1; vt = 20'd1; r = 22'd65536; side = 22'd262144; end
				2: begin vc = 20'd0; vt = 20'd1; r = 22'h1FFFFF; side = 22'h3FFFFF; end
				default: begin
					vc = 20'($urandom_range(1, 20'hFFFFF));
					vt = 20'($urandom_range(1, 20'hFFFFF));
					side = 22'($urandom_range(1, 22'h3FFFFF));
					r = 22'($urandom_range(0, side));
				end
			endcase
			load_setting(vc, vt, r, side);
			random_phase(130, path_span(vc, vt, r, side));
			if (p == 3) begin
				stall_enable = 1'b0;
				drain_results();
				random_phase(60, path_span(vc, vt, r, side));
				stall_enable = 1'b1;
			end
			drain_results();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
